>>> hdl/bpu_pkg.sv
// Shared types and constants of the BMP pixel unpacker.
// Used by bpu_front, bpu_queue, bpu_back and bmp_pixel_unpacker; no dependencies.
`default_nettype none

package bpu_pkg;

   localparam int DIM_W           = 13;
   localparam int COORD_W         = 12;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 24;
   localparam int DEF_MAX_WIDTH   = 4096;
   localparam int DEF_MAX_HEIGHT  = 4096;
   localparam int DEF_QUEUE_DEPTH = 4;

   // depth_mode codes; code 3 behaves as 32 bpp
   localparam logic [1:0] MODE_MONO = 2'd0;
   localparam logic [1:0] MODE_RGB  = 2'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WIDTH    = 3'd0,
      CSR_HEIGHT   = 3'd1,
      CSR_DEPTH    = 3'd2,
      CSR_TOP_DOWN = 3'd3,
      CSR_ORDER    = 3'd4,
      CSR_PAL_ZERO = 3'd5,
      CSR_PAL_ONE  = 3'd6
   } csr_index_type;

   localparam logic [DIM_W-1:0] RST_WIDTH    = 13'd1;
   localparam logic [DIM_W-1:0] RST_HEIGHT   = 13'd1;
   localparam logic [1:0]       RST_DEPTH    = MODE_RGB;
   localparam logic             RST_TOP_DOWN = 1'b0;
   localparam logic [7:0]       RST_ORDER    = 8'd198;
   localparam logic [23:0]      RST_PAL_ZERO = 24'h000000;
   localparam logic [23:0]      RST_PAL_ONE  = 24'hFFFFFF;

   typedef struct packed {
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
      logic [1:0]       depth_mode;
      logic             top_down;
      logic [7:0]       channel_order;
      logic [23:0]      palette_zero;
      logic [23:0]      palette_one;
   } cfg_type;

   // one queued job: a run of up to eight 1 bpp pixels, or one finished color pixel
   typedef struct packed {
      logic               mono;
      logic [7:0]         bits;
      logic [3:0]         count;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
   } job_type;

endpackage

`default_nettype wire

>>> hdl/bpu_front.sv
// Front end: accepts raw bytes, tracks row position and padding, builds jobs.
// Depends on bpu_pkg.
`default_nettype none

module bpu_front #(
   parameter int MAX_WIDTH  = bpu_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bpu_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bpu_pkg::cfg_type cfg,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_pixel_byte,
   input  wire logic             q_full,
   output logic                  q_push,
   output bpu_pkg::job_type      q_job
);
   import bpu_pkg::*;

   localparam int DimMax = (1 << DIM_W) - 1;
   localparam logic [DIM_W-1:0] MaxW = (MAX_WIDTH  > DimMax) ? DIM_W'(DimMax) : DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MaxH = (MAX_HEIGHT > DimMax) ? DIM_W'(DimMax) : DIM_W'(MAX_HEIGHT);

   logic [14:0]      rbp_ff, rbp_in;
   logic [DIM_W-1:0] col_ff, col_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic [23:0]      gather_ff, gather_in;
   logic [1:0]       phase_ff, phase_in;

   logic             accept;
   logic [DIM_W-1:0] w, h, rem, y_flip;
   logic             mono, rgb, in_data, has_col, capture;
   logic [14:0]      data_bytes, padded, rbp_next;
   logic [15:0]      pad_sum;
   logic [3:0]       n_pix;
   logic [1:0]       last_phase;
   logic [7:0]       b0, b1, b2, b3;
   logic [31:0]      pix_bytes;

   function automatic logic [7:0] pick(logic [31:0] bytes, logic [1:0] idx);
      return bytes[8*idx +: 8];
   endfunction

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      priority if (cfg.image_width == '0) begin
         w = DIM_W'(1);
      end else if (cfg.image_width > MaxW) begin
         w = MaxW;
      end else begin
         w = cfg.image_width;
      end
      priority if (cfg.image_height == '0) begin
         h = DIM_W'(1);
      end else if (cfg.image_height > MaxH) begin
         h = MaxH;
      end else begin
         h = cfg.image_height;
      end

      mono = (cfg.depth_mode == MODE_MONO);
      rgb  = (cfg.depth_mode == MODE_RGB);
      priority if (mono) begin
         data_bytes = 15'((16'(w) + 16'd7) >> 3);
      end else if (rgb) begin
         data_bytes = 15'({2'b00, w} << 1) + 15'(w);
      end else begin
         data_bytes = 15'({w, 2'b00});
      end
      pad_sum = (16'(data_bytes) + 16'd3) & ~16'd3;
      padded  = pad_sum[14:0];

      y_flip  = h - DIM_W'(1) - row_ff;
      in_data = (rbp_ff < data_bytes);
      has_col = (col_ff < w);
      rem     = w - col_ff;
      n_pix   = (rem >= DIM_W'(8)) ? 4'd8 : rem[3:0];

      last_phase = rgb ? 2'd2 : 2'd3;
      capture    = (phase_ff < last_phase);

      b0 = gather_ff[7:0];
      b1 = gather_ff[15:8];
      b2 = rgb ? req_pixel_byte : gather_ff[23:16];
      b3 = rgb ? 8'd0 : req_pixel_byte;
      pix_bytes = {b3, b2, b1, b0};

      q_job.mono  = mono;
      q_job.bits  = req_pixel_byte;
      q_job.count = mono ? n_pix : 4'd1;
      q_job.x     = col_ff[COORD_W-1:0];
      q_job.y     = cfg.top_down ? row_ff[COORD_W-1:0] : y_flip[COORD_W-1:0];
      q_job.red   = pick(pix_bytes, cfg.channel_order[1:0]);
      q_job.green = pick(pix_bytes, cfg.channel_order[3:2]);
      q_job.blue  = pick(pix_bytes, cfg.channel_order[5:4]);
      q_job.alpha = rgb ? 8'd255 : pick(pix_bytes, cfg.channel_order[7:6]);

      q_push = accept && in_data && has_col && (mono || !capture);

      // next state, applied only on an accepted beat
      rbp_in    = rbp_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      gather_in = gather_ff;
      phase_in  = phase_ff;
      rbp_next  = rbp_ff + 15'd1;
      if (accept) begin
         if (in_data) begin
            if (mono) begin
               if (has_col) begin
                  col_in = col_ff + DIM_W'(n_pix);
               end
            end else if (capture) begin
               unique case (phase_ff)
                  2'd0:    gather_in[7:0]   = req_pixel_byte;
                  2'd1:    gather_in[15:8]  = req_pixel_byte;
                  default: gather_in[23:16] = req_pixel_byte;
               endcase
               phase_in = phase_ff + 2'd1;
            end else begin
               if (has_col) begin
                  col_in = col_ff + DIM_W'(1);
               end
               phase_in = 2'd0;
            end
         end
         rbp_in = rbp_next;
         // end of padded row: restart column, wrap the row counter
         if (rbp_next >= padded) begin
            rbp_in   = '0;
            col_in   = '0;
            phase_in = 2'd0;
            row_in   = ((14'(row_ff) + 14'd1) >= 14'(h)) ? '0 : row_ff + DIM_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rbp_ff    <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         gather_ff <= '0;
         phase_ff  <= '0;
      end else begin
         rbp_ff    <= rbp_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         gather_ff <= gather_in;
         phase_ff  <= phase_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/bpu_queue.sv
// Job queue between front and back: a small register FIFO.
// Depends on bpu_pkg.
`default_nettype none

module bpu_queue #(
   parameter int DEPTH = bpu_pkg::DEF_QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire bpu_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output bpu_pkg::job_type      head_job
);
   import bpu_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);

   job_type       mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == (AW+1)'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + AW'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + (AW+1)'(1);
         2'b01:   count_in = count_ff - (AW+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

>>> hdl/bpu_back.sv
// Back end: expands jobs into output-register pixels, one per cycle unless stalled.
// Depends on bpu_pkg.
`default_nettype none

module bpu_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [23:0]      palette_zero,
   input  wire logic [23:0]      palette_one,
   input  wire logic             q_valid,
   input  wire bpu_pkg::job_type q_job,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [11:0]           rsp_pos_x,
   output logic [11:0]           rsp_pos_y,
   output logic [7:0]            rsp_red,
   output logic [7:0]            rsp_green,
   output logic [7:0]            rsp_blue,
   output logic [7:0]            rsp_alpha,
   output logic                  rsp_last_of_run
);
   import bpu_pkg::*;

   job_type     cur_ff, cur_in;
   logic        cur_valid_ff, cur_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] x_ff, y_ff;
   logic [7:0]  r_ff, g_ff, b_ff, a_ff;
   logic        last_ff;
   logic        emit, cur_done;
   logic [31:0] pix;

   assign emit     = cur_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign cur_done = emit && (cur_ff.count == 4'd1);
   assign q_pop    = q_valid && (!cur_valid_ff || cur_done);

   always_comb begin
      if (!cur_ff.mono) begin
         pix = {cur_ff.red, cur_ff.green, cur_ff.blue, cur_ff.alpha};
      end else if (cur_ff.bits[7]) begin
         pix = {palette_one, 8'd255};
      end else begin
         pix = {palette_zero, 8'd0};
      end

      cur_in = cur_ff;
      if (q_pop) begin
         cur_in = q_job;
      end else if (emit) begin
         // advance to the next bit of the run
         cur_in.bits  = {cur_ff.bits[6:0], 1'b0};
         cur_in.count = cur_ff.count - 4'd1;
         cur_in.x     = cur_ff.x + 12'd1;
      end
      cur_valid_in = q_pop ? 1'b1 : (cur_done ? 1'b0 : cur_valid_ff);
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         x_ff    <= cur_ff.x;
         y_ff    <= cur_ff.y;
         r_ff    <= pix[31:24];
         g_ff    <= pix[23:16];
         b_ff    <= pix[15:8];
         a_ff    <= pix[7:0];
         last_ff <= (cur_ff.count == 4'd1);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = x_ff;
   assign rsp_pos_y       = y_ff;
   assign rsp_red         = r_ff;
   assign rsp_green       = g_ff;
   assign rsp_blue        = b_ff;
   assign rsp_alpha       = a_ff;
   assign rsp_last_of_run = last_ff;

endmodule

`default_nettype wire

>>> hdl/bmp_pixel_unpacker.sv
// BMP pixel unpacker: one raw pixel-array byte in per beat, RGBA pixels with x/y out.
// A byte's job passes the job queue, current-job register, then output register.
// Throughput: one byte per cycle in 24/32 bpp while the queue has room; the back end
// issues one pixel per cycle unless stalled, so a 1 bpp byte holds it for its n pixels.
// Reset (synchronous): counters, job queue and output valid cleared; registers to defaults.
// Depends on bpu_pkg, bpu_front, bpu_queue, bpu_back.
`default_nettype none

module bmp_pixel_unpacker #(
   parameter int MAX_WIDTH   = bpu_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT  = bpu_pkg::DEF_MAX_HEIGHT,
   parameter int QUEUE_DEPTH = bpu_pkg::DEF_QUEUE_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [bpu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bpu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [7:0]                      req_pixel_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [11:0]                          rsp_pos_x,
   output logic [11:0]                          rsp_pos_y,
   output logic [7:0]                           rsp_red,
   output logic [7:0]                           rsp_green,
   output logic [7:0]                           rsp_blue,
   output logic [7:0]                           rsp_alpha,
   output logic                                 rsp_last_of_run
);
   import bpu_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    q_push, q_full, q_pop, q_valid;
   job_type push_job, head_job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WIDTH:    cfg_in.image_width   = csr_wdata[DIM_W-1:0];
            CSR_HEIGHT:   cfg_in.image_height  = csr_wdata[DIM_W-1:0];
            CSR_DEPTH:    cfg_in.depth_mode    = csr_wdata[1:0];
            CSR_TOP_DOWN: cfg_in.top_down      = csr_wdata[0];
            CSR_ORDER:    cfg_in.channel_order = csr_wdata[7:0];
            CSR_PAL_ZERO: cfg_in.palette_zero  = csr_wdata[23:0];
            CSR_PAL_ONE:  cfg_in.palette_one   = csr_wdata[23:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= RST_WIDTH;
         cfg_ff.image_height  <= RST_HEIGHT;
         cfg_ff.depth_mode    <= RST_DEPTH;
         cfg_ff.top_down      <= RST_TOP_DOWN;
         cfg_ff.channel_order <= RST_ORDER;
         cfg_ff.palette_zero  <= RST_PAL_ZERO;
         cfg_ff.palette_one   <= RST_PAL_ONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bpu_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_byte (req_pixel_byte),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_job          (push_job)
   );

   bpu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (head_job)
   );

   bpu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .palette_zero    (cfg_ff.palette_zero),
      .palette_one     (cfg_ff.palette_one),
      .q_valid         (q_valid),
      .q_job           (head_job),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_alpha       (rsp_alpha),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // output register comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // a run taken before its last pixel continues with no bubble
   a_run_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_of_run) |=> rsp_valid)
      else $error("gap inside a pixel run");

   // pixels of one run sit in adjacent columns of one row
   a_run_columns: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_of_run) |=>
      (rsp_pos_x == 12'($past(rsp_pos_x) + 12'd1)) && (rsp_pos_y == $past(rsp_pos_y)))
      else $error("run pixels not adjacent");

   // queue never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("job pushed into full queue");

endmodule

`default_nettype wire
